### src/lif_pkg.sv
// Shared types, codes and q15 helpers for the leaky integrate-and-fire layer.
// Used by the controller, the datapath, the top level and the checker.
package lif_pkg;

   localparam int MASK_W      = 16;
   localparam int DATA_W      = 16;
   localparam int COUNT_W     = 5;
   localparam int KIND_W      = 2;
   localparam int ADDR_W      = 8;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_FF_WRITE  = 2'd0,
      KIND_REC_WRITE = 2'd1,
      KIND_TIMESTEP  = 2'd2,
      KIND_CLEAR     = 2'd3
   } lif_kind_type;

   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REST       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INPUTS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NEURONS    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SUBTRACT   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_TO_ONE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_RECURRENT  = 3'd7;

   localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 16'sd546;
   localparam logic signed [DATA_W-1:0] DECAY_RESET     = 16'sd26214;
   localparam logic signed [DATA_W-1:0] REST_RESET      = 16'sd0;
   localparam logic [COUNT_W-1:0]       INPUTS_RESET    = 5'd3;
   localparam logic [COUNT_W-1:0]       NEURONS_RESET   = 5'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic start;
      logic neuron_first;
      logic input_step;
      logic rec_add;
      logic mul_stage;
      logic write_back;
      logic load_result;
   } lif_cmd_type;

   // Loop status from the datapath to the controller.
   typedef struct packed {
      logic nn_zero;
      logic ni_zero;
      logic last_input;
      logic last_neuron;
   } lif_status_type;

   function automatic logic signed [DATA_W-1:0] sat17(input logic signed [DATA_W:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[DATA_W] != v[DATA_W-1]) begin
         r = v[DATA_W] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] add_sat(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      return sat17(s);
   endfunction

   function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      return sat17(s);
   endfunction

endpackage

### src/lif_ctrl.sv
// Sequencer for the layer: walks neurons and input lines and drives the datapath.
// Depends on lif_pkg for the command and status structs and the item kinds.
module lif_ctrl
   import lif_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [KIND_W-1:0]   req_kind,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  lif_status_type      status,
   output lif_cmd_type         cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_NEURON = 8'b0000_0010,
      ST_ACCUM  = 8'b0000_0100,
      ST_DRAIN  = 8'b0000_1000,
      ST_RECUR  = 8'b0001_0000,
      ST_MUL    = 8'b0010_0000,
      ST_WRITE  = 8'b0100_0000,
      ST_RESULT = 8'b1000_0000
   } lif_state_type;

   lif_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && (req_kind == KIND_TIMESTEP)) begin
               cmd.start = 1'b1;
               state_in  = status.nn_zero ? ST_RESULT : ST_NEURON;
            end
         end
         ST_NEURON: begin
            cmd.neuron_first = 1'b1;
            state_in         = status.ni_zero ? ST_RECUR : ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.input_step = 1'b1;
            if (status.last_input) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last weight read lands in the accumulator here.
            state_in = ST_RECUR;
         end
         ST_RECUR: begin
            cmd.rec_add = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_stage = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write_back = 1'b1;
            state_in       = status.last_neuron ? ST_RESULT : ST_NEURON;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/lif_datapath.sv
// Datapath of the layer: settings, weight memory, neuron state, accumulator and update.
// Depends on lif_pkg; driven by lif_ctrl through the command struct.
module lif_datapath
   import lif_pkg::*;
#(
   parameter int MAX_INPUTS  = 16,
   parameter int MAX_NEURONS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]             csr_write_data,
   input  logic [KIND_W-1:0]             req_kind,
   input  logic [ADDR_W-1:0]             req_weight_address,
   input  logic signed [DATA_W-1:0]      req_weight_value,
   input  logic [MASK_W-1:0]             req_input_spike_mask,
   input  logic [MASK_W-1:0]             req_recurrent_spike_mask,
   output logic [MASK_W-1:0]             rsp_spike_mask,
   input  lif_cmd_type                   cmd,
   output lif_status_type                status
);

   localparam int IN_LIM   = (MAX_INPUTS < MASK_W) ? MAX_INPUTS : MASK_W;
   localparam int IIDX_W   = (IN_LIM > 1) ? $clog2(IN_LIM) : 1;
   localparam int NIDX_W   = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
   localparam int FF_DEPTH = MAX_INPUTS * MAX_NEURONS;
   localparam int FF_AW    = (FF_DEPTH > 1) ? $clog2(FF_DEPTH) : 1;
   localparam int CNT_W    = 7;

   // Settings
   logic signed [DATA_W-1:0] threshold_ff, decay_ff, rest_ff;
   logic [COUNT_W-1:0]       inputs_ff, neurons_ff;
   logic                     subtract_ff, one_to_one_ff, recurrent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         decay_ff      <= DECAY_RESET;
         rest_ff       <= REST_RESET;
         inputs_ff     <= INPUTS_RESET;
         neurons_ff    <= NEURONS_RESET;
         subtract_ff   <= 1'b1;
         one_to_one_ff <= 1'b0;
         recurrent_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_THRESHOLD:  threshold_ff  <= csr_write_data;
            REG_DECAY:      decay_ff      <= csr_write_data;
            REG_REST:       rest_ff       <= csr_write_data;
            REG_INPUTS:     inputs_ff     <= csr_write_data[COUNT_W-1:0];
            REG_NEURONS:    neurons_ff    <= csr_write_data[COUNT_W-1:0];
            REG_SUBTRACT:   subtract_ff   <= csr_write_data[0];
            REG_ONE_TO_ONE: one_to_one_ff <= csr_write_data[0];
            REG_RECURRENT:  recurrent_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Active counts, clamped to what the layer holds. Input lines past the
   // mask width never spike, so they are not walked at all.
   logic [CNT_W-1:0] ni_cnt, nn_cnt;
   logic [CNT_W-1:0] inputs_ext, neurons_ext;

   assign inputs_ext  = CNT_W'(inputs_ff);
   assign neurons_ext = CNT_W'(neurons_ff);
   assign ni_cnt = (inputs_ext > CNT_W'(IN_LIM)) ? CNT_W'(IN_LIM) : inputs_ext;
   assign nn_cnt = (neurons_ext > CNT_W'(MAX_NEURONS)) ? CNT_W'(MAX_NEURONS) : neurons_ext;

   // Loop counters
   logic [IIDX_W-1:0] i_ff, i_in;
   logic [NIDX_W-1:0] j_ff, j_in;

   assign status.nn_zero     = (nn_cnt == '0);
   assign status.ni_zero     = (ni_cnt == '0);
   assign status.last_input  = ((CNT_W'(i_ff) + CNT_W'(1)) == ni_cnt);
   assign status.last_neuron = ((CNT_W'(j_ff) + CNT_W'(1)) == nn_cnt);

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.start) begin
         j_in = '0;
      end else if (cmd.write_back) begin
         j_in = j_ff + NIDX_W'(1);
      end
      if (cmd.neuron_first) begin
         i_in = '0;
      end else if (cmd.input_step) begin
         i_in = i_ff + IIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

   // Timestep masks
   logic [MASK_W-1:0] imask_ff, rmask_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         imask_ff <= req_input_spike_mask;
         rmask_ff <= req_recurrent_spike_mask;
      end
   end

   // Feedforward weight memory, input-major, one registered read per cycle.
   logic signed [DATA_W-1:0] ffw_mem [FF_DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;
   logic [FF_AW-1:0]         addr_ff, addr_in, rd_addr;
   logic                     ffw_we;

   assign ffw_we = cmd.accept && (req_kind == KIND_FF_WRITE)
                   && ({24'd0, req_weight_address} < 32'(FF_DEPTH));
   assign rd_addr = one_to_one_ff ? FF_AW'(i_ff) : addr_ff;

   always_ff @(posedge clock) begin
      if (ffw_we) begin
         ffw_mem[FF_AW'(req_weight_address)] <= req_weight_value;
      end
      rdata_ff <= ffw_mem[rd_addr];
   end

   // The full-connectivity address steps by the neuron count per input line.
   always_comb begin
      addr_in = addr_ff;
      if (cmd.neuron_first) begin
         addr_in = FF_AW'(j_ff);
      end else if (cmd.input_step) begin
         addr_in = addr_ff + FF_AW'(nn_cnt);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   // Recurrent self-weights
   logic signed [DATA_W-1:0] rw_ff [MAX_NEURONS];
   logic                     rw_we;

   assign rw_we = cmd.accept && (req_kind == KIND_REC_WRITE)
                  && ({24'd0, req_weight_address} < 32'(MAX_NEURONS));

   always_ff @(posedge clock) begin
      if (rw_we) begin
         rw_ff[NIDX_W'(req_weight_address)] <= req_weight_value;
      end
   end

   // Current accumulator. A read issued in one cycle is added in the next.
   logic                     hit, rbit;
   logic                     pend_ff, pend_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;

   assign hit  = imask_ff[4'(i_ff)]
                 && (!one_to_one_ff || (CNT_W'(i_ff) == CNT_W'(j_ff)));
   assign rbit = (CNT_W'(j_ff) < CNT_W'(MASK_W)) ? rmask_ff[4'(j_ff)] : 1'b0;
   assign pend_in = cmd.input_step && hit;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.neuron_first) begin
         acc_in = '0;
      end else if (pend_ff) begin
         acc_in = add_sat(acc_ff, rdata_ff);
      end else if (cmd.rec_add && recurrent_ff && rbit) begin
         acc_in = add_sat(acc_ff, rw_ff[j_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      acc_ff <= acc_in;
   end

   // Neuron state
   logic signed [DATA_W-1:0] mem_ff [MAX_NEURONS];
   logic signed [DATA_W-1:0] car_ff [MAX_NEURONS];
   logic signed [DATA_W-1:0] v_cur, car_cur, op_a;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] m_val, base_val, sum_val, v_new, mem_wb, car_wb;
   logic                     fire, clear_req;

   assign v_cur   = mem_ff[j_ff];
   assign car_cur = car_ff[j_ff];

   // Hard mode leaks the distance from rest; subtract mode leaks the membrane.
   assign op_a = subtract_ff ? v_cur : sub_sat(v_cur, rest_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_stage) begin
         prod_ff <= op_a * decay_ff;
      end
   end

   // Arithmetic shift by 15 is the floor of the q15 product.
   assign m_val    = sat17(prod_ff[2*DATA_W-1:DATA_W-1]);
   assign base_val = subtract_ff ? m_val : add_sat(rest_ff, m_val);
   assign sum_val  = add_sat(base_val, acc_ff);
   assign v_new    = subtract_ff ? sub_sat(sum_val, car_cur) : sum_val;
   assign fire     = (v_new > threshold_ff);
   assign mem_wb   = (!subtract_ff && fire) ? rest_ff : v_new;
   assign car_wb   = fire ? threshold_ff : '0;

   assign clear_req = cmd.accept && (req_kind == KIND_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_NEURONS; k++) begin
            mem_ff[k] <= '0;
            car_ff[k] <= '0;
         end
      end else if (clear_req) begin
         for (int k = 0; k < MAX_NEURONS; k++) begin
            mem_ff[k] <= subtract_ff ? car_ff[k] : rest_ff;
         end
      end else if (cmd.write_back) begin
         mem_ff[j_ff] <= mem_wb;
         if (subtract_ff) begin
            car_ff[j_ff] <= car_wb;
         end
      end
   end

   // Spike collection and the output register.
   logic [MASK_W-1:0] spikes_ff, spikes_in;
   logic [MASK_W-1:0] rsp_mask_ff;

   always_comb begin
      spikes_in = spikes_ff;
      if (cmd.start) begin
         spikes_in = '0;
      end else if (cmd.write_back && fire && (CNT_W'(j_ff) < CNT_W'(MASK_W))) begin
         spikes_in[4'(j_ff)] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      spikes_ff <= spikes_in;
      if (cmd.load_result) begin
         rsp_mask_ff <= spikes_ff;
      end
   end

   assign rsp_spike_mask = rsp_mask_ff;

endmodule

### src/lif_neuron_layer_step_core.sv
// A layer of leaky integrate-and-fire neurons in q15. Items of four kinds arrive on the req_
// channel: feedforward weight writes, recurrent weight writes and clears complete in the cycle
// they are taken and give no result, while a timestep gives one spike mask on the rsp_
// channel. A timestep holds the layer while a single saturating accumulator reads the
// feedforward weight memory once per cycle for every input line of every neuron, then adds
// the recurrent weight and updates the membrane through one registered multiplier. Items are
// processed one at a time; a finished result waits in an output register, so the next item
// is taken while it is still stalled, and a timestep that finishes while that register is
// still full waits until it is transferred. The user must write settings through the csr_
// port only while the layer is idle; the block itself does not enforce this.
module lif_neuron_layer_step_core
   import lif_pkg::*;
#(
   parameter int MAX_INPUTS  = 16,
   parameter int MAX_NEURONS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]        csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [ADDR_W-1:0]        req_weight_address,
   input  logic signed [DATA_W-1:0] req_weight_value,
   input  logic [MASK_W-1:0]        req_input_spike_mask,
   input  logic [MASK_W-1:0]        req_recurrent_spike_mask,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [MASK_W-1:0]        rsp_spike_mask
);

   lif_cmd_type    cmd;
   lif_status_type status;

   lif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lif_datapath #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_NEURONS (MAX_NEURONS)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_kind                 (req_kind),
      .req_weight_address       (req_weight_address),
      .req_weight_value         (req_weight_value),
      .req_input_spike_mask     (req_input_spike_mask),
      .req_recurrent_spike_mask (req_recurrent_spike_mask),
      .rsp_spike_mask           (rsp_spike_mask),
      .cmd                      (cmd),
      .status                   (status)
   );

endmodule

### src/lif_checker.sv
// Port-level checks for the layer, attached to the top level by the bind below.
// Depends on lif_pkg for the item kinds.
module lif_checker
   import lif_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [KIND_W-1:0]        req_kind,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [MASK_W-1:0]        rsp_spike_mask
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its spike mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_spike_mask))
      else $error("spike mask changed while stalled");

   // A timestep transfer always occupies the layer for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_TIMESTEP) |=> req_stall)
      else $error("layer free right after a timestep transfer");

   // Weight writes and clears complete in the cycle they are taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind != KIND_TIMESTEP) |=> !req_stall)
      else $error("layer busy after a weight write or clear");

endmodule

bind lif_neuron_layer_step_core lif_checker u_lif_checker (.*);
